// ===== rtl/whp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whp_pkg
// Types and constants for the 802.11 MAC header parser: the frame record passed
// from the byte collector to the classifier, frame codes and header offsets.
// ----------------------------------------------------------------------------
package whp_pkg;

    localparam int unsigned HDR_BYTES = 40;

    typedef logic [HDR_BYTES-1:0][7:0] t_hdr;

    typedef struct packed {
        t_hdr        hdr;
        logic [15:0] len;
        logic [15:0] start;
    } t_frame_rec;

    localparam logic [2:0] CLS_UNDEF = 3'd0;
    localparam logic [2:0] CLS_IPV4  = 3'd1;
    localparam logic [2:0] CLS_ARP   = 3'd2;
    localparam logic [2:0] CLS_IPV6  = 3'd3;
    localparam logic [2:0] CLS_ERROR = 3'd4;

    localparam logic [1:0] TYPE_MGMT = 2'd0;
    localparam logic [1:0] TYPE_CTRL = 2'd1;
    localparam logic [1:0] TYPE_DATA = 2'd2;
    localparam logic [1:0] TYPE_RSVD = 2'd3;

    localparam logic [3:0] SUB_PROBE_REQ = 4'd4;
    localparam logic [3:0] SUB_DISASSOC  = 4'd10;
    localparam logic [3:0] SUB_AUTH      = 4'd11;
    localparam logic [3:0] SUB_DEAUTH    = 4'd12;

    localparam logic [3:0] SUB_BAR       = 4'd8;
    localparam logic [3:0] SUB_BA        = 4'd9;
    localparam logic [3:0] SUB_PS_POLL   = 4'd10;
    localparam logic [3:0] SUB_RTS       = 4'd11;
    localparam logic [3:0] SUB_CTS       = 4'd12;
    localparam logic [3:0] SUB_ACK       = 4'd13;
    localparam logic [3:0] SUB_CF_END    = 4'd14;
    localparam logic [3:0] SUB_CF_END_AK = 4'd15;

    localparam logic [3:0] SUB_DATA_RSVD = 4'd13;

    localparam int unsigned ADDR1_OFF = 4;
    localparam int unsigned ADDR2_OFF = 10;
    localparam int unsigned ADDR3_OFF = 16;
    localparam int unsigned ADDR4_OFF = 24;

    localparam logic [15:0] MIN_FRAME_LEN = 16'd12;
    localparam logic [15:0] MIN_HDR_LEN   = 16'd24;

    localparam logic [7:0] HLEN_3ADDR   = 8'd24;
    localparam logic [7:0] HLEN_4ADDR   = 8'd30;
    localparam logic [7:0] HLEN_QOS     = 8'd2;
    localparam logic [7:0] HLEN_MGMT    = 8'd24;
    localparam logic [7:0] HLEN_MGMT_LG = 8'd32;
    localparam logic [7:0] HLEN_CTL_TA  = 8'd16;
    localparam logic [7:0] HLEN_CTL_RA  = 8'd10;
    localparam logic [7:0] HLEN_BAR     = 8'd20;
    localparam logic [7:0] HLEN_BA      = 8'd148;
    localparam logic [7:0] HLEN_SNAP    = 8'd8;

    localparam logic [7:0] DATA_OFF_A = 8'd24;
    localparam logic [7:0] DATA_OFF_B = 8'd26;
    localparam logic [7:0] DATA_OFF_C = 8'd30;
    localparam logic [7:0] DATA_OFF_D = 8'd32;

    localparam logic [7:0]  LLC_SAP  = 8'hAA;
    localparam logic [7:0]  LLC_CTRL = 8'h03;

    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_ARP  = 16'h0806;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;

    function automatic logic [47:0] mac_at(input t_hdr h, input int unsigned off);
        logic [47:0] v;
        v = '0;
        for (int k = 0; k < 6; k++) begin
            v = {v[39:0], h[off + k]};
        end
        return v;
    endfunction

endpackage

// ===== rtl/whp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whp_front
// Byte collector. Counts the bytes of a frame, keeps the leading header bytes
// and, on the last byte, hands a complete frame record to the queue.
// ----------------------------------------------------------------------------
module whp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    input  logic [15:0]        i_header_start,
    input  logic               i_full,
    output logic               o_stall,
    output logic               o_push,
    output whp_pkg::t_frame_rec o_rec
);
    import whp_pkg::*;

    logic [7:0]  r_hdr [HDR_BYTES];
    logic [15:0] r_count;
    logic [15:0] n_count;
    logic [15:0] r_start;
    logic        accept;
    logic [15:0] len;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept && i_last_byte;
    assign len     = (r_count == 16'hFFFF) ? r_count : r_count + 16'd1;
    assign n_count = i_last_byte ? 16'd0 : len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_start <= '0;
        end else if (accept) begin
            r_count <= n_count;
            if (r_count == 16'd0) begin
                r_start <= i_header_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < HDR_BYTES; i++) begin
            if (accept && r_count == 16'(i)) begin
                r_hdr[i] <= i_data_byte;
            end
        end
    end

    always_comb begin
        o_rec.len   = len;
        o_rec.start = (r_count == 16'd0) ? i_header_start : r_start;
        for (int i = 0; i < HDR_BYTES; i++) begin
            if (16'(i) >= len) begin
                o_rec.hdr[i] = 8'h00;
            end else if (16'(i) == r_count) begin
                o_rec.hdr[i] = i_data_byte;
            end else begin
                o_rec.hdr[i] = r_hdr[i];
            end
        end
    end

endmodule

// ===== rtl/whp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whp_queue
// Two-entry frame record queue between the byte collector and the classifier.
// ----------------------------------------------------------------------------
module whp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  whp_pkg::t_frame_rec i_rec,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_head_valid,
    output whp_pkg::t_frame_rec o_head
);
    import whp_pkg::*;

    t_frame_rec r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full       = (r_count == 2'd2);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("Frame record pushed into a full queue.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("Frame record popped from an empty queue.");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("Queue holds more records than it has entries.");
`endif

endmodule

// ===== rtl/whp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whp_back
// Frame classifier. Decodes the header of one frame record, selects the
// addresses, works out the header length and class, and holds the result in
// the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module whp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rec_valid,
    input  whp_pkg::t_frame_rec i_rec,
    output logic                o_pop,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [2:0]          o_frame_class,
    output logic [1:0]          o_frame_type,
    output logic [3:0]          o_frame_subtype,
    output logic [47:0]         o_dst_addr,
    output logic [47:0]         o_src_addr,
    output logic [47:0]         o_bssid_addr,
    output logic [16:0]         o_body_start,
    output logic [15:0]         o_body_size
);
    import whp_pkg::*;

    logic        r_valid;
    logic [2:0]  r_cls;
    logic [1:0]  r_type;
    logic [3:0]  r_sub;
    logic [47:0] r_dst;
    logic [47:0] r_src;
    logic [47:0] r_bssid;
    logic [16:0] r_pstart;
    logic [15:0] r_psize;

    logic [2:0]  n_cls;
    logic [1:0]  n_type;
    logic [3:0]  n_sub;
    logic [47:0] n_dst;
    logic [47:0] n_src;
    logic [47:0] n_bssid;
    logic [16:0] n_pstart;
    logic [15:0] n_psize;

    logic        load;

    always_comb begin
        t_hdr        h;
        logic [15:0] len;
        logic        tods;
        logic        fromds;
        logic [7:0]  offt;
        logic        err;
        logic        fixed;
        logic [7:0][7:0] win;
        logic [15:0] ethertype;

        h      = i_rec.hdr;
        len    = i_rec.len;
        n_type = h[0][3:2];
        n_sub  = h[0][7:4];
        tods   = h[1][0];
        fromds = h[1][1];
        offt   = '0;
        err    = 1'b0;
        fixed  = 1'b0;
        n_cls  = CLS_UNDEF;
        n_dst  = '0;
        n_src  = '0;
        n_bssid = '0;
        n_pstart = '0;
        n_psize  = '0;
        win      = '0;
        ethertype = '0;

        if (len < MIN_FRAME_LEN) begin
            err = 1'b1;
        end else begin
            unique case (n_type)
                TYPE_MGMT: begin
                    if (len < MIN_HDR_LEN) begin
                        err = 1'b1;
                    end else if (n_sub == SUB_PROBE_REQ) begin
                        n_dst   = mac_at(h, ADDR2_OFF);
                        n_src   = mac_at(h, ADDR2_OFF);
                        n_bssid = mac_at(h, ADDR2_OFF);
                        offt    = HLEN_MGMT;
                    end else begin
                        n_dst   = mac_at(h, ADDR1_OFF);
                        n_src   = mac_at(h, ADDR2_OFF);
                        n_bssid = mac_at(h, ADDR3_OFF);
                        offt    = (n_sub == SUB_DISASSOC || n_sub == SUB_AUTH ||
                                   n_sub == SUB_DEAUTH) ? HLEN_MGMT : HLEN_MGMT_LG;
                    end
                end
                TYPE_CTRL: begin
                    priority if (n_sub == SUB_PS_POLL || n_sub == SUB_RTS ||
                                 n_sub == SUB_CF_END || n_sub == SUB_CF_END_AK) begin
                        n_dst = mac_at(h, ADDR1_OFF);
                        n_src = mac_at(h, ADDR2_OFF);
                        offt  = HLEN_CTL_TA;
                    end else if (n_sub == SUB_CTS || n_sub == SUB_ACK) begin
                        n_dst = mac_at(h, ADDR1_OFF);
                        offt  = HLEN_CTL_RA;
                    end else if (n_sub == SUB_BAR) begin
                        n_dst = mac_at(h, ADDR1_OFF);
                        n_src = mac_at(h, ADDR2_OFF);
                        offt  = HLEN_BAR;
                    end else if (n_sub == SUB_BA) begin
                        n_dst = mac_at(h, ADDR1_OFF);
                        n_src = mac_at(h, ADDR2_OFF);
                        offt  = HLEN_BA;
                    end else begin
                        offt = '0;
                    end
                end
                TYPE_DATA: begin
                    if (len < MIN_HDR_LEN) begin
                        err = 1'b1;
                    end else begin
                        if (n_sub[3] && n_sub != SUB_DATA_RSVD) begin
                            offt = HLEN_QOS;
                        end
                        unique case ({tods, fromds})
                            2'b00: begin
                                n_dst   = mac_at(h, ADDR1_OFF);
                                n_src   = mac_at(h, ADDR2_OFF);
                                n_bssid = mac_at(h, ADDR3_OFF);
                                offt    = offt + HLEN_3ADDR;
                            end
                            2'b01: begin
                                n_dst   = mac_at(h, ADDR1_OFF);
                                n_bssid = mac_at(h, ADDR2_OFF);
                                n_src   = mac_at(h, ADDR3_OFF);
                                offt    = offt + HLEN_3ADDR;
                            end
                            2'b10: begin
                                n_bssid = mac_at(h, ADDR1_OFF);
                                n_src   = mac_at(h, ADDR2_OFF);
                                n_dst   = mac_at(h, ADDR3_OFF);
                                offt    = offt + HLEN_3ADDR;
                            end
                            default: begin
                                if (len < 16'(offt) + 16'(HLEN_4ADDR)) begin
                                    err = 1'b1;
                                end else begin
                                    n_bssid = mac_at(h, ADDR2_OFF);
                                    n_dst   = mac_at(h, ADDR1_OFF);
                                    n_src   = mac_at(h, ADDR4_OFF);
                                    offt    = offt + HLEN_4ADDR;
                                end
                            end
                        endcase

                        unique case (offt)
                            DATA_OFF_A: for (int k = 0; k < 8; k++) win[k] = h[24 + k];
                            DATA_OFF_B: for (int k = 0; k < 8; k++) win[k] = h[26 + k];
                            DATA_OFF_C: for (int k = 0; k < 8; k++) win[k] = h[30 + k];
                            DATA_OFF_D: for (int k = 0; k < 8; k++) win[k] = h[32 + k];
                            default:    win = '0;
                        endcase
                        ethertype = {win[6], win[7]};

                        if (!err) begin
                            if (n_sub[2]) begin
                                n_pstart = 17'(i_rec.start) + 17'(offt);
                                n_psize  = '0;
                                fixed    = 1'b1;
                            end else if (16'(offt) + 16'(HLEN_SNAP) > len) begin
                                err = 1'b1;
                            end else if (win[0] != LLC_SAP || win[1] != LLC_SAP ||
                                         win[2] != LLC_CTRL) begin
                                n_pstart = 17'(i_rec.start) + 17'(offt);
                                n_psize  = len - 16'(offt);
                                fixed    = 1'b1;
                            end else begin
                                offt = offt + HLEN_SNAP;
                                priority if (ethertype == ETH_IPV4) begin
                                    n_cls = CLS_IPV4;
                                end else if (ethertype == ETH_ARP) begin
                                    n_cls = CLS_ARP;
                                end else if (ethertype == ETH_IPV6) begin
                                    n_cls = CLS_IPV6;
                                end else begin
                                    n_cls = CLS_UNDEF;
                                end
                            end
                        end
                    end
                end
                TYPE_RSVD: begin
                    err = 1'b1;
                end
                default: begin
                    err = 1'b1;
                end
            endcase
        end

        if (!err && !fixed) begin
            if (16'(offt) > len) begin
                err = 1'b1;
            end else begin
                n_pstart = 17'(i_rec.start) + 17'(offt);
                n_psize  = len - 16'(offt);
            end
        end

        if (err) begin
            n_cls    = CLS_ERROR;
            n_dst    = '0;
            n_src    = '0;
            n_bssid  = '0;
            n_pstart = '0;
            n_psize  = '0;
        end
    end

    assign load  = i_rec_valid && (!r_valid || !i_stall);
    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cls    <= n_cls;
            r_type   <= n_type;
            r_sub    <= n_sub;
            r_dst    <= n_dst;
            r_src    <= n_src;
            r_bssid  <= n_bssid;
            r_pstart <= n_pstart;
            r_psize  <= n_psize;
        end
    end

    assign o_valid         = r_valid;
    assign o_frame_class   = r_cls;
    assign o_frame_type    = r_type;
    assign o_frame_subtype = r_sub;
    assign o_dst_addr      = r_dst;
    assign o_src_addr      = r_src;
    assign o_bssid_addr    = r_bssid;
    assign o_body_start    = r_pstart;
    assign o_body_size     = r_psize;

`ifndef SYNTH
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_cls == CLS_ERROR) |->
        (r_dst == '0 && r_src == '0 && r_bssid == '0 && r_pstart == '0 && r_psize == '0))
        else $error("Error result carries nonzero address or payload fields.");

    a_cls_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_cls == CLS_IPV4 || r_cls == CLS_ARP || r_cls == CLS_IPV6)) |->
        (r_type == TYPE_DATA))
        else $error("Protocol class given to a frame that is not a data frame.");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=>
        (r_valid && $stable({r_cls, r_type, r_sub, r_dst, r_src, r_bssid,
                             r_pstart, r_psize})))
        else $error("Stalled result transfer changed before it was taken.");
`endif

endmodule

// ===== rtl/wlan_header_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlan_header_parser
// 802.11 MAC header parser: classifies a frame from its header bytes and gives
// its addresses, payload position and payload size.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one frame byte per transfer, MAC header first, with
// i_last_byte marking the final byte; i_header_start is sampled on the first
// byte of each frame. The output channel carries one result per frame.
// A transfer takes place on a rising edge with valid high and stall low.
// Throughput is one byte per cycle while o_stall is low; frames of any length,
// down to a single byte, may follow each other with no gap.
// The record of a frame enters the queue on the edge that transfers its last
// byte, and the output register, which presents the result, on a later edge,
// once the record heads the queue and the output register is free.
// A two-entry queue sits between the byte collector and the classifier. While
// the receiver stalls, bytes keep being taken until the queue holds two
// finished frames, after which o_stall is raised until the receiver drains.
// Reset clears the byte count, the queue and the output valid; no result is
// pending after reset, and the next byte starts a new frame.
// ----------------------------------------------------------------------------
module wlan_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_header_start,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_frame_class,
    output logic [1:0]  o_frame_type,
    output logic [3:0]  o_frame_subtype,
    output logic [47:0] o_dst_addr,
    output logic [47:0] o_src_addr,
    output logic [47:0] o_bssid_addr,
    output logic [16:0] o_body_start,
    output logic [15:0] o_body_size
);
    import whp_pkg::*;

    logic       push;
    logic       pop;
    logic       full;
    logic       head_valid;
    t_frame_rec push_rec;
    t_frame_rec head_rec;

    whp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_header_start (i_header_start),
        .i_full         (full),
        .o_stall        (o_stall),
        .o_push         (push),
        .o_rec          (push_rec)
    );

    whp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_rec        (push_rec),
        .i_pop        (pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head_rec)
    );

    whp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rec_valid     (head_valid),
        .i_rec           (head_rec),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_frame_class   (o_frame_class),
        .o_frame_type    (o_frame_type),
        .o_frame_subtype (o_frame_subtype),
        .o_dst_addr      (o_dst_addr),
        .o_src_addr      (o_src_addr),
        .o_bssid_addr    (o_bssid_addr),
        .o_body_start    (o_body_start),
        .o_body_size     (o_body_size)
    );

endmodule
